### rtl/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker: widths, register indexes,
// packet phase codes and the configuration record.
// Depends on nothing; every other file imports it.
`default_nettype none

package ps2mt_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned SMOOTH_W = 12;
    localparam int unsigned FACTOR_W = 9;
    localparam int unsigned TARGET_W = 10;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] SMOOTH_RESET = 9'd77;
    localparam logic [FACTOR_W-1:0] SMOOTH_MAX   = 9'd256;
    localparam logic [COORD_W-1:0]  WIDTH_RESET  = 8'd80;
    localparam logic [COORD_W-1:0]  HEIGHT_RESET = 8'd24;
    localparam logic [COORD_W-1:0]  POS_X_RESET  = 8'd5;
    localparam logic [COORD_W-1:0]  POS_Y_RESET  = 8'd2;

    // Header byte bits.
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned BTN_LEFT   = 0;
    localparam int unsigned BTN_RIGHT  = 1;
    localparam int unsigned BTN_MIDDLE = 2;

    // Packet phase codes.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DX     = 2'd1;
    localparam logic [1:0] PH_DY     = 2'd2;
    localparam logic [1:0] PH_UNUSED = 2'd3;

    typedef struct packed {
        logic [FACTOR_W-1:0] smooth_factor;
        logic [COORD_W-1:0]  screen_width;
        logic [COORD_W-1:0]  screen_height;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/ps2mt_if.sv
// Handshake interfaces of the PS/2 mouse packet tracker: raw bytes in,
// cursor results out, and the register write channel. Uses ps2mt_pkg.
`default_nettype none

interface ps2mt_byte_if;
    import ps2mt_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ps2mt_cursor_if;
    import ps2mt_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic               left_pressed;
    logic               right_pressed;
    logic               middle_pressed;
    modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                    output right_pressed, output middle_pressed, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                    input right_pressed, input middle_pressed, output ready);
endinterface

interface ps2mt_cfg_if;
    import ps2mt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FACTOR_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: input byte register, tracker
// core, result register and configuration registers.
// Depends on ps2mt_pkg, the ps2mt interfaces, ps2mt_cfg_regs and ps2mt_tracker_core.
//
//   channel   direction  beat
//   i_byte    in         one raw mouse byte (data_byte)
//   o_cursor  out        cursor_x, cursor_y and three button states, one per packet
//   i_cfg     in         register index and write data, always ready
//
// A byte is registered on acceptance and processed from the input register;
// the byte that completes a packet loads the result register as it is processed.
// One byte is taken every cycle unless a stalled result holds the input register;
// the input and result registers each hold one beat, and a stalled result blocks only a byte that completes a packet.
// Reset is synchronous and active low and brings back the power-up cursor.
`default_nettype none

module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    ps2mt_byte_if.sink       i_byte,
    ps2mt_cursor_if.source   o_cursor,
    ps2mt_cfg_if.sink        i_cfg
);

    t_cfg              cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [2:0]        r_out_btn;

    logic              packet_done;
    logic [COORD_W-1:0] core_x;
    logic [COORD_W-1:0] core_y;
    logic [2:0]        core_btn;
    logic              out_free;
    logic              step;

    ps2mt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ps2mt_tracker_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_cfg         (cfg),
        .o_packet_done (packet_done),
        .o_cursor_x    (core_x),
        .o_cursor_y    (core_y),
        .o_buttons     (core_btn)
    );

    assign out_free     = !r_out_valid || o_cursor.ready;
    assign step         = r_in_valid && (!packet_done || out_free);
    assign i_byte.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && packet_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && packet_done) begin
            r_out_x   <= core_x;
            r_out_y   <= core_y;
            r_out_btn <= core_btn;
        end
    end

    assign o_cursor.valid          = r_out_valid;
    assign o_cursor.cursor_x       = r_out_x;
    assign o_cursor.cursor_y       = r_out_y;
    assign o_cursor.left_pressed   = r_out_btn[0];
    assign o_cursor.right_pressed  = r_out_btn[1];
    assign o_cursor.middle_pressed = r_out_btn[2];

endmodule

`default_nettype wire

### rtl/ps2mt_cfg_regs.sv
// Configuration registers: smoothing factor and screen size.
// Depends on ps2mt_pkg and ps2mt_cfg_if.
`default_nettype none

module ps2mt_cfg_regs
    import ps2mt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ps2mt_cfg_if.sink   i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_factor <= SMOOTH_RESET;
            r_cfg.screen_width  <= WIDTH_RESET;
            r_cfg.screen_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SMOOTH_FACTOR: r_cfg.smooth_factor <= i_cfg.data;
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg.data[COORD_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg.data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/ps2mt_smooth.sv
// One axis of cursor smoothing: blends the target into the last smoothed
// value by a 1/256 factor, truncating toward zero, then clamps to the screen.
// Depends on ps2mt_pkg.
`default_nettype none

module ps2mt_smooth
    import ps2mt_pkg::*;
(
    input  wire logic signed [SMOOTH_W-1:0] i_last,
    input  wire logic signed [TARGET_W-1:0] i_target,
    input  wire logic        [FACTOR_W-1:0] i_factor,
    input  wire logic        [COORD_W-1:0]  i_dim,
    output logic signed      [SMOOTH_W-1:0] o_next,
    output logic             [COORD_W-1:0]  o_pos
);

    localparam int unsigned DIFF_W = SMOOTH_W + 1;
    localparam int unsigned NUM_W  = DIFF_W + FACTOR_W + 1;
    localparam int unsigned Q_W    = NUM_W - 8;

    logic        [FACTOR_W-1:0] factor;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [NUM_W-1:0]    prod;
    logic signed [NUM_W-1:0]    num;
    logic signed [Q_W-1:0]      quot;
    logic        [COORD_W-1:0]  dim;

    always_comb begin
        factor = (i_factor > SMOOTH_MAX) ? SMOOTH_MAX : i_factor;
        diff   = DIFF_W'(i_target) - DIFF_W'(i_last);
        prod   = NUM_W'(diff) * $signed({1'b0, factor});
        num    = (NUM_W'(i_last) <<< 8) + prod;
        // Arithmetic shift floors; a negative value with a remainder moves up by one.
        quot   = num[NUM_W-1:8];
        if (num[NUM_W-1] && (num[7:0] != 8'd0)) begin
            quot = quot + Q_W'(1);
        end
        o_next = quot[SMOOTH_W-1:0];

        dim = (i_dim == '0) ? COORD_W'(1) : i_dim;
        if (quot[Q_W-1]) begin
            o_pos = '0;
        end else if (quot >= $signed({{(Q_W-COORD_W){1'b0}}, dim})) begin
            o_pos = dim - COORD_W'(1);
        end else begin
            o_pos = quot[COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/ps2mt_tracker_core.sv
// Packet assembly and cursor state: takes registered bytes, keeps the header
// and X delta, and on the Y delta forms the new cursor and smoothed values.
// Depends on ps2mt_pkg and ps2mt_smooth.
`default_nettype none

module ps2mt_tracker_core
    import ps2mt_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  wire  [BYTE_W-1:0]   i_byte,
    input  wire  t_cfg          i_cfg,
    output logic                o_packet_done,
    output logic [COORD_W-1:0]  o_cursor_x,
    output logic [COORD_W-1:0]  o_cursor_y,
    output logic [2:0]          o_buttons
);

    logic [1:0]                 r_phase;
    logic [BYTE_W-1:0]          r_header;
    logic [BYTE_W-1:0]          r_dx;
    logic [COORD_W-1:0]         r_pos_x;
    logic [COORD_W-1:0]         r_pos_y;
    logic signed [SMOOTH_W-1:0] r_sm_x;
    logic signed [SMOOTH_W-1:0] r_sm_y;

    logic signed [TARGET_W-1:0] tx;
    logic signed [TARGET_W-1:0] ty;
    logic signed [SMOOTH_W-1:0] n_sm_x;
    logic signed [SMOOTH_W-1:0] n_sm_y;
    logic        [COORD_W-1:0]  n_pos_x;
    logic        [COORD_W-1:0]  n_pos_y;

    always_comb begin
        tx = $signed({{(TARGET_W-COORD_W){1'b0}}, r_pos_x})
           + $signed({{(TARGET_W-BYTE_W){r_dx[BYTE_W-1]}}, r_dx});
        ty = $signed({{(TARGET_W-COORD_W){1'b0}}, r_pos_y})
           - $signed({{(TARGET_W-BYTE_W){i_byte[BYTE_W-1]}}, i_byte});
    end

    ps2mt_smooth u_smooth_x (
        .i_last   (r_sm_x),
        .i_target (tx),
        .i_factor (i_cfg.smooth_factor),
        .i_dim    (i_cfg.screen_width),
        .o_next   (n_sm_x),
        .o_pos    (n_pos_x)
    );

    ps2mt_smooth u_smooth_y (
        .i_last   (r_sm_y),
        .i_target (ty),
        .i_factor (i_cfg.smooth_factor),
        .i_dim    (i_cfg.screen_height),
        .o_next   (n_sm_y),
        .o_pos    (n_pos_y)
    );

    assign o_packet_done = (r_phase == PH_DY);
    assign o_cursor_x    = n_pos_x;
    assign o_cursor_y    = n_pos_y;
    assign o_buttons     = {r_header[BTN_MIDDLE], r_header[BTN_RIGHT], r_header[BTN_LEFT]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_header <= '0;
            r_dx     <= '0;
            r_pos_x  <= POS_X_RESET;
            r_pos_y  <= POS_Y_RESET;
            r_sm_x   <= '0;
            r_sm_y   <= '0;
        end else if (i_step) begin
            unique case (r_phase)
                PH_DX: begin
                    r_dx    <= i_byte;
                    r_phase <= PH_DY;
                end
                PH_DY: begin
                    r_sm_x  <= n_sm_x;
                    r_sm_y  <= n_sm_y;
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_phase <= PH_HEADER;
                end
                PH_HEADER, PH_UNUSED: begin
                    // Bytes without the sync bit are dropped while hunting for a header.
                    if (i_byte[SYNC_BIT]) begin
                        r_header <= i_byte;
                        r_phase  <= PH_DX;
                    end else begin
                        r_phase  <= PH_HEADER;
                    end
                end
                default: r_phase <= PH_HEADER;
            endcase
        end
    end

endmodule

`default_nettype wire
